/* rtl/npm_pkg.sv */
// npm_pkg: types, widths and codes shared by the nearest point matcher
// depends on nothing; imported by npm_dist and nearest_point_matcher_top
`default_nettype none

package npm_pkg;

    localparam int MAX_TARGETS = 8192;
    localparam int IDX_W       = $clog2(MAX_TARGETS);
    localparam int CNT_W       = $clog2(MAX_TARGETS + 1);
    localparam int COORD_W     = 20;
    localparam int AXIS_W      = COORD_W;
    localparam int SQ_W        = 2 * AXIS_W;
    localparam int DIST_W      = 42;
    localparam int POINT_W     = 3 * COORD_W;

    localparam logic [DIST_W-1:0] THRESH_RESET = DIST_W'(1717987);

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_QUERY  = 2'd2
    } cmd_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } point_t;

    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] idx;
    } tag_t;

endpackage

`default_nettype wire

/* rtl/nearest_point_matcher_top.sv */
// nearest_point_matcher_top: brute force nearest target search over a point store
// depends on npm_pkg, npm_ram and npm_dist
//
//  channel  direction  handshake               beat
//  item     in         item_valid/item_stall   cmd, x, y, z
//  result   out        result_valid/result_stall  match_index, dist_sq, found,
//                                              within_threshold, overflow
//  cfg      in         cfg_valid/cfg_ready     cfg_data (max_dist_sq)
//
// clear empties the store and append adds a target, neither giving a result; a query
// scans every stored target and puts out one result (no scan on an empty store), with one
// stored target read per cycle through the single read port
// the store has no reset; only entries below the target count are ever read
// item_stall is high while a query scans or its result waits for the output register
// a finished result sits in the output register while clears and appends go on
`default_nettype none

module nearest_point_matcher_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    output logic                              item_stall,
    input  logic [1:0]                        cmd,
    input  logic signed [npm_pkg::COORD_W-1:0] x,
    input  logic signed [npm_pkg::COORD_W-1:0] y,
    input  logic signed [npm_pkg::COORD_W-1:0] z,
    output logic                              result_valid,
    input  logic                              result_stall,
    output logic [npm_pkg::IDX_W-1:0]         match_index,
    output logic [npm_pkg::DIST_W-1:0]        dist_sq,
    output logic                              found,
    output logic                              within_threshold,
    output logic                              overflow,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [npm_pkg::DIST_W-1:0]        cfg_data
);
    import npm_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_RESULT = 3'b100
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  issue_reg, issue_next;
    logic              ovf_reg, ovf_next;
    logic [DIST_W-1:0] thr_reg;
    point_t            query_reg, query_next;
    tag_t              rd_tag_reg, rd_tag_next;
    logic              found_reg, found_next;
    logic [DIST_W-1:0] best_d_reg, best_d_next;
    logic [IDX_W-1:0]  best_idx_reg, best_idx_next;
    logic              result_valid_reg, result_valid_next;
    logic [IDX_W-1:0]  match_index_reg, match_index_next;
    logic [DIST_W-1:0] dist_sq_reg, dist_sq_next;
    logic              found_out_reg, found_out_next;
    logic              within_reg, within_next;
    logic              ovf_out_reg, ovf_out_next;

    logic              item_accept;
    logic              wr_en;
    logic              rd_en;
    point_t            item_point;
    logic [POINT_W-1:0] rd_data;
    point_t            target_point;
    logic [DIST_W-1:0] scan_dist;
    tag_t              dist_tag;
    logic              dist_busy;

    assign item_stall   = (state_reg != ST_IDLE);
    assign item_accept  = item_valid && !item_stall;
    assign cfg_ready    = 1'b1;
    assign item_point   = '{x: x, y: y, z: z};
    assign target_point = point_t'(rd_data);
    assign wr_en        = item_accept && (cmd_t'(cmd) == CMD_APPEND)
                          && (count_reg < CNT_W'(MAX_TARGETS));
    assign rd_en        = (state_reg == ST_SCAN) && (issue_reg < count_reg);

    npm_ram #(
        .WIDTH (POINT_W),
        .DEPTH (MAX_TARGETS)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data (item_point),
        .rd_en   (rd_en),
        .rd_addr (issue_reg[IDX_W-1:0]),
        .rd_data (rd_data)
    );

    npm_dist u_dist (
        .clk     (clk),
        .rst_n   (rst_n),
        .query   (query_reg),
        .target  (target_point),
        .tag_in  (rd_tag_reg),
        .sum_sq  (scan_dist),
        .tag_out (dist_tag),
        .busy    (dist_busy)
    );

    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        issue_next        = issue_reg;
        ovf_next          = ovf_reg;
        query_next        = query_reg;
        rd_tag_next       = '0;
        found_next        = found_reg;
        best_d_next       = best_d_reg;
        best_idx_next     = best_idx_reg;
        result_valid_next = result_valid_reg;
        match_index_next  = match_index_reg;
        dist_sq_next      = dist_sq_reg;
        found_out_next    = found_out_reg;
        within_next       = within_reg;
        ovf_out_next      = ovf_out_reg;

        if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (item_accept)
                begin
                    case (cmd_t'(cmd))
                        CMD_CLEAR:
                        begin
                            count_next = '0;
                        end
                        CMD_APPEND:
                        begin
                            if (wr_en)
                            begin
                                count_next = count_reg + 1'b1;
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                        CMD_QUERY:
                        begin
                            query_next    = item_point;
                            issue_next    = '0;
                            found_next    = 1'b0;
                            best_d_next   = '0;
                            best_idx_next = '0;
                            state_next    = (count_reg == '0) ? ST_RESULT : ST_SCAN;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (rd_en)
                begin
                    rd_tag_next = '{valid: 1'b1, idx: issue_reg[IDX_W-1:0]};
                    issue_next  = issue_reg + 1'b1;
                end
                if (dist_tag.valid && (!found_reg || scan_dist < best_d_reg))
                begin
                    found_next    = 1'b1;
                    best_d_next   = scan_dist;
                    best_idx_next = dist_tag.idx;
                end
                if (!rd_en && !rd_tag_reg.valid && !dist_busy)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    result_valid_next = 1'b1;
                    match_index_next  = best_idx_reg;
                    dist_sq_next      = best_d_reg;
                    found_out_next    = found_reg;
                    within_next       = found_reg && (best_d_reg <= thr_reg);
                    ovf_out_next      = ovf_reg;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            count_reg        <= '0;
            issue_reg        <= '0;
            ovf_reg          <= 1'b0;
            thr_reg          <= THRESH_RESET;
            rd_tag_reg       <= '0;
            found_reg        <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            issue_reg        <= issue_next;
            ovf_reg          <= ovf_next;
            rd_tag_reg       <= rd_tag_next;
            found_reg        <= found_next;
            result_valid_reg <= result_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                thr_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        query_reg       <= query_next;
        best_d_reg      <= best_d_next;
        best_idx_reg    <= best_idx_next;
        match_index_reg <= match_index_next;
        dist_sq_reg     <= dist_sq_next;
        found_out_reg   <= found_out_next;
        within_reg      <= within_next;
        ovf_out_reg     <= ovf_out_next;
    end

    assign result_valid     = result_valid_reg;
    assign match_index      = match_index_reg;
    assign dist_sq          = dist_sq_reg;
    assign found            = found_out_reg;
    assign within_threshold = within_reg;
    assign overflow         = ovf_out_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_TARGETS))
        else $error("target count beyond store depth");

    a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (issue_reg <= count_reg))
        else $error("scan read past the target count");

    a_pipe_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (rd_tag_reg.valid || dist_tag.valid) |-> (state_reg == ST_SCAN))
        else $error("distance pipeline active outside a scan");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(state_reg == ST_RESULT))
        else $error("result raised without a finished query");

    a_found_dist: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && !found_out_reg) |-> (dist_sq_reg == '0 && !within_reg))
        else $error("empty store result carries a distance");

endmodule

`default_nettype wire

/* rtl/npm_ram.sv */
// npm_ram: generic single write port, single read port ram with registered read
// depends on nothing; holds the target point store
`default_nettype none

module npm_ram #(
    parameter int WIDTH = 60,
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* rtl/npm_dist.sv */
// npm_dist: three stage squared euclidean distance pipeline with tag
// depends on npm_pkg; fed by the point store read port
`default_nettype none

module npm_dist (
    input  logic                               clk,
    input  logic                               rst_n,
    input  npm_pkg::point_t                    query,
    input  npm_pkg::point_t                    target,
    input  npm_pkg::tag_t                      tag_in,
    output logic [npm_pkg::DIST_W-1:0]         sum_sq,
    output npm_pkg::tag_t                      tag_out,
    output logic                               busy
);
    import npm_pkg::*;

    logic [AXIS_W-1:0] ax_reg, ay_reg, az_reg;
    logic [SQ_W-1:0]   sx_reg, sy_reg, sz_reg;
    logic [DIST_W-1:0] dist_reg;
    tag_t              tag1_reg, tag2_reg, tag3_reg;
    logic [AXIS_W-1:0] ax_next, ay_next, az_next;

    function automatic logic [AXIS_W-1:0] abs_diff(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b
    );
        logic signed [COORD_W:0] d;
        logic        [COORD_W:0] m;
        d = $signed({a[COORD_W-1], a}) - $signed({b[COORD_W-1], b});
        m = d[COORD_W] ? (~d + 1'b1) : d;
        return m[AXIS_W-1:0];
    endfunction

    always_comb
    begin
        ax_next = abs_diff(query.x, target.x);
        ay_next = abs_diff(query.y, target.y);
        az_next = abs_diff(query.z, target.z);
    end

    always_ff @(posedge clk)
    begin
        ax_reg   <= ax_next;
        ay_reg   <= ay_next;
        az_reg   <= az_next;
        sx_reg   <= ax_reg * ax_reg;
        sy_reg   <= ay_reg * ay_reg;
        sz_reg   <= az_reg * az_reg;
        dist_reg <= DIST_W'(sx_reg) + DIST_W'(sy_reg) + DIST_W'(sz_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg <= '0;
            tag2_reg <= '0;
            tag3_reg <= '0;
        end
        else
        begin
            tag1_reg <= tag_in;
            tag2_reg <= tag1_reg;
            tag3_reg <= tag2_reg;
        end
    end

    assign sum_sq  = dist_reg;
    assign tag_out = tag3_reg;
    assign busy    = tag1_reg.valid | tag2_reg.valid | tag3_reg.valid;

endmodule

`default_nettype wire
